@@ design/gray_coverage_to_argb_pixels_unit_defines.svh @@
// Assertion macros for the gray coverage to ARGB pixel unit.
// Used by the top level; expects clk and rst in scope.
`ifndef GRAY_COVERAGE_TO_ARGB_PIXELS_UNIT_DEFINES_SVH
`define GRAY_COVERAGE_TO_ARGB_PIXELS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GCA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gca: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gca: next-cycle check failed");

`endif

@@ design/gca_pkg.sv @@
// Shared constants and types for the gray coverage to ARGB pixel unit.
// No dependencies.
`timescale 1ns / 1ps

package gca_pkg;

  localparam int CovW    = 8;
  localparam int PixW    = 32;
  localparam int ColorW  = 32;
  localparam int WidthW  = 12;
  localparam int HeightW = 13;
  localparam int PosW    = 12;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  localparam logic [HeightW-1:0] MaxHeight = 13'd4096;
  localparam logic [23:0]        RgbMask   = 24'hFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLOR  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef logic [CovW-1:0] coverage_t;
  typedef logic [PixW-1:0] pixel_t;

endpackage

@@ design/gca_coverage_if.sv @@
// Coverage byte channel: valid/ready handshake with one coverage byte.
// Depends on gca_pkg.
`timescale 1ns / 1ps

interface gca_coverage_if;
  logic                valid;
  logic                ready;
  gca_pkg::coverage_t  coverage;

  modport source (output valid, output coverage, input ready);
  modport sink   (input valid, input coverage, output ready);
endinterface

@@ design/gca_pixel_if.sv @@
// Pixel channel: valid/ready handshake with one ARGB pixel and last flag.
// Depends on gca_pkg.
`timescale 1ns / 1ps

interface gca_pixel_if;
  logic             valid;
  logic             ready;
  gca_pkg::pixel_t  pixel;
  logic             last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

@@ design/gray_coverage_to_argb_pixels_unit.sv @@
// Gray coverage bitmap to ARGB pixel converter, top level.
// Depends on gca_pkg, gca_coverage_if, gca_pixel_if and the defines header.
//
// Usage:
//   coverage_ch carries one byte of the padded glyph bitmap per item; rows
//   are glyph_width bytes padded to a multiple of four. pixel_ch carries one
//   ARGB pixel per real coverage byte; padding items give no result.
//   last_pixel marks the final pixel of the last row.
//   cfg_we/cfg_index/cfg_data write color_argb (0), glyph_width (1) and
//   glyph_height (2); write only while no item is in flight.
// Timing:
//   A pixel appears on pixel_ch in the cycle after its coverage byte is taken.
//   Throughput is one item per cycle while pixel_ch is ready; the limit is the single output
//   register, which refills in the cycle it is drained.
// Reset:
//   Synchronous, active high: registers return to color 0xFF000000, width 1,
//   height 1, and the row/column counters to the start of a glyph.
// Stall:
//   While pixel_ch holds a pixel that is not taken, coverage_ch.ready is low;
//   the pending pixel and its flag hold steady.
`timescale 1ns / 1ps
`include "gray_coverage_to_argb_pixels_unit_defines.svh"

module gray_coverage_to_argb_pixels_unit (
  input  logic                           clk,
  input  logic                           rst,
  gca_coverage_if.sink                   coverage_ch,
  gca_pixel_if.source                    pixel_ch,
  input  logic                           cfg_we,
  input  logic [gca_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [gca_pkg::CfgW-1:0]       cfg_data
);

  logic [gca_pkg::ColorW-1:0]  color_argb;
  logic [gca_pkg::WidthW-1:0]  glyph_width;
  logic [gca_pkg::HeightW-1:0] glyph_height;

  logic [gca_pkg::PosW-1:0] column_pos;
  logic [gca_pkg::PosW-1:0] row_pos;
  logic [gca_pkg::PosW-1:0] column_pos_next;
  logic [gca_pkg::PosW-1:0] row_pos_next;

  logic                     out_valid;
  gca_pkg::pixel_t          out_pixel;
  logic                     out_last;

  logic [gca_pkg::WidthW-1:0]  eff_w;
  logic [gca_pkg::WidthW-1:0]  w_last;
  logic [gca_pkg::WidthW-1:0]  pad_last;
  logic [gca_pkg::HeightW-1:0] eff_h;
  logic [gca_pkg::PosW-1:0]    h_last;
  logic                        last_row;
  logic                        emit;
  logic                        in_fire;
  logic [9:0]                  scale;
  logic [17:0]                 product;
  gca_pkg::pixel_t             pixel_n;
  logic                        last_n;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color_argb   <= 32'hFF00_0000;
      glyph_width  <= 12'd1;
      glyph_height <= 13'd1;
    end else if (cfg_we) begin
      case (gca_pkg::cfg_reg_t'(cfg_index))
        gca_pkg::REG_COLOR:  color_argb   <= cfg_data;
        gca_pkg::REG_WIDTH:  glyph_width  <= cfg_data[gca_pkg::WidthW-1:0];
        gca_pkg::REG_HEIGHT: glyph_height <= cfg_data[gca_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry; last byte of a padded row is (w-1) | 3
  always_comb begin
    eff_w    = (glyph_width == '0) ? 12'd1 : glyph_width;
    w_last   = eff_w - 12'd1;
    pad_last = w_last | 12'd3;
    if (glyph_height == '0) begin
      eff_h = 13'd1;
    end else if (glyph_height > gca_pkg::MaxHeight) begin
      eff_h = gca_pkg::MaxHeight;
    end else begin
      eff_h = glyph_height;
    end
    h_last   = gca_pkg::PosW'(eff_h - 13'd1);
    last_row = (row_pos >= h_last);
    emit     = (column_pos < eff_w);
  end

  assign coverage_ch.ready = !out_valid || pixel_ch.ready;
  assign in_fire           = coverage_ch.valid && coverage_ch.ready;

  // alpha = A * (4c - 1) / 256, low 8 bits kept
  always_comb begin
    scale   = {coverage_ch.coverage, 2'b00} - 10'd1;
    product = color_argb[31:24] * scale;
    if (coverage_ch.coverage == '0) begin
      pixel_n = '0;
    end else begin
      pixel_n = {product[15:8], color_argb[23:0] & gca_pkg::RgbMask};
    end
    last_n = last_row && (column_pos == w_last);
  end

  always_comb begin
    if (column_pos >= pad_last) begin
      column_pos_next = '0;
      row_pos_next    = last_row ? '0 : row_pos + 12'd1;
    end else begin
      column_pos_next = column_pos + 12'd1;
      row_pos_next    = row_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (in_fire) begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (pixel_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_pixel <= pixel_n;
      out_last  <= last_n;
    end
  end

  assign pixel_ch.valid      = out_valid;
  assign pixel_ch.pixel      = out_pixel;
  assign pixel_ch.last_pixel = out_last;

  `GCA_ASSERT_SAME(a_ready_when_empty, !out_valid, coverage_ch.ready)
  `GCA_ASSERT_NEXT(a_pixel_after_real_byte, in_fire && emit, out_valid)
  `GCA_ASSERT_NEXT(a_no_pixel_for_padding, in_fire && !emit, !out_valid)
  `GCA_ASSERT_NEXT(a_wrap_after_last_row, in_fire && last_row && column_pos >= pad_last,
                   column_pos == '0 && row_pos == '0)

endmodule

@@ test/gray_coverage_to_argb_pixels_unit_tb.sv @@
// Testbench for gray_coverage_to_argb_pixels_unit: drives coverage bytes and register writes,
// predicts ARGB pixels and glyph-end flags, and checks every pixel item in order.
// Depends on gca_pkg, gca_coverage_if, gca_pixel_if and the unit itself.
`timescale 1ns / 1ps

module gray_coverage_to_argb_pixels_unit_tb;

  typedef struct {
    gca_pkg::pixel_t pixel;
    logic            last_pixel;
  } glyph_pixel_t;

  // Tracks color, glyph size and the row/column walk, and queues the pixels still to come.
  class argb_scoreboard;
    logic [gca_pkg::ColorW-1:0]  color;
    logic [gca_pkg::WidthW-1:0]  width;
    logic [gca_pkg::HeightW-1:0] height;
    logic [gca_pkg::PosW-1:0]    col_pos;
    logic [gca_pkg::PosW-1:0]    row_pos;
    glyph_pixel_t                pending[$];
    int                          errors;
    int                          checked;
    int                          glyph_ends;
    int                          reg_writes;

    function new();
      color      = 32'hFF00_0000;
      width      = 12'd1;
      height     = 13'd1;
      col_pos    = '0;
      row_pos    = '0;
      errors     = 0;
      checked    = 0;
      glyph_ends = 0;
      reg_writes = 0;
    endfunction

    function void write_reg(gca_pkg::cfg_reg_t idx, logic [gca_pkg::CfgW-1:0] data);
      reg_writes++;
      case (idx)
        gca_pkg::REG_COLOR:  color  = data;
        gca_pkg::REG_WIDTH:  width  = data[gca_pkg::WidthW-1:0];
        gca_pkg::REG_HEIGHT: height = data[gca_pkg::HeightW-1:0];
        default: ;
      endcase
    endfunction

    function void note_coverage(gca_pkg::coverage_t c);
      int           w;
      int           h;
      int           padded;
      int           alpha;
      bit           last_row;
      glyph_pixel_t e;
      w = (width == 0) ? 1 : int'(width);
      h = (height == 0) ? 1 : ((height > gca_pkg::MaxHeight) ? 4096 : int'(height));
      padded = ((w + 3) / 4) * 4;
      last_row = int'(row_pos) >= h - 1;
      if (int'(col_pos) < w) begin
        e.pixel = '0;
        if (c != 0) begin
          alpha = (int'(color[31:24]) * (4 * int'(c) - 1)) / 256;
          e.pixel = {alpha[7:0], color[23:0]};
        end
        e.last_pixel = last_row && (int'(col_pos) == w - 1);
        pending.push_back(e);
      end
      // A column past the padded end (after a width change) also closes the row.
      if (int'(col_pos) >= padded - 1) begin
        col_pos = '0;
        row_pos = last_row ? '0 : row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    endfunction

    function void check_pixel(gca_pkg::pixel_t p, logic lp);
      glyph_pixel_t e;
      if (pending.size() == 0) begin
        $display("%0t: pixel %h last %b with none expected", $time, p, lp);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (p !== e.pixel) begin
        $display("%0t: pixel expected %h actual %h", $time, e.pixel, p);
        errors++;
      end
      if (lp !== e.last_pixel) begin
        $display("%0t: last_pixel expected %b actual %b", $time, e.last_pixel, lp);
        errors++;
      end
      checked++;
      if (e.last_pixel) glyph_ends++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [gca_pkg::CfgIdxW-1:0] cfg_index;
  logic [gca_pkg::CfgW-1:0] cfg_data;

  gca_coverage_if cov_ch();
  gca_pixel_if    pix_ch();

  gray_coverage_to_argb_pixels_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .coverage_ch (cov_ch),
    .pixel_ch    (pix_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  argb_scoreboard sb = new();
  int items_sent   = 0;
  int pixels_taken = 0;
  int hold_left    = 0;

  always #5 clk = ~clk;

  // Pixel receiver: random back-pressure, a quiet window, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        pixels_taken++;
        if (pixels_taken == 500) hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= (pixels_taken >= 250 && pixels_taken < 450) ||
                        ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) sb.check_pixel(pix_ch.pixel, pix_ch.last_pixel);
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_coverage(input gca_pkg::coverage_t c);
    while (!(items_sent >= 300 && items_sent < 500) && $urandom_range(99) < 16) begin
      cov_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cov_ch.valid    <= 1'b1;
    cov_ch.coverage <= c;
    do @(posedge clk); while (!cov_ch.ready);
    sb.note_coverage(c);
    items_sent++;
  endtask

  function automatic gca_pkg::coverage_t rand_coverage();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return gca_pkg::coverage_t'($urandom_range(255));
      3:       return ($urandom_range(1) != 0) ? 8'hFF : 8'h40;
      default: return gca_pkg::coverage_t'($urandom_range(64));
    endcase
  endfunction

  // Lowers valid and lets the last pixel (and any trailing padding) clear.
  task automatic drain();
    cov_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input gca_pkg::cfg_reg_t idx,
                           input logic [gca_pkg::CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic reconfigure(input bit wr_color, input logic [gca_pkg::CfgW-1:0] color,
                             input bit wr_width, input logic [gca_pkg::CfgW-1:0] width,
                             input bit wr_height, input logic [gca_pkg::CfgW-1:0] height);
    if (wr_color)  write_reg(gca_pkg::REG_COLOR, color);
    if (wr_width)  write_reg(gca_pkg::REG_WIDTH, width);
    if (wr_height) write_reg(gca_pkg::REG_HEIGHT, height);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [gca_pkg::CfgW-1:0] color;
    logic [gca_pkg::CfgW-1:0] width;
    logic [gca_pkg::CfgW-1:0] height;
    int                       n;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = gca_pkg::REG_COLOR;
    cfg_data        = '0;
    cov_ch.valid    = 1'b0;
    cov_ch.coverage = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: one pixel per padded row, every row is the last.
    send_coverage(8'h00); send_coverage(8'hAA); send_coverage(8'h55); send_coverage(8'hFF);
    send_coverage(8'h01); send_coverage(8'h00); send_coverage(8'h00); send_coverage(8'h00);
    drain();

    reconfigure(1'b1, 32'h8012_3456, 1'b1, 32'd5, 1'b1, 32'd2);
    send_coverage(8'd64); send_coverage(8'hFF); send_coverage(8'h80); send_coverage(8'h7F);
    send_coverage(8'h01); send_coverage(8'h33); send_coverage(8'hCC); send_coverage(8'h00);
    send_coverage(8'h02); send_coverage(8'h03); send_coverage(8'h04); send_coverage(8'h05);
    send_coverage(8'h40); send_coverage(8'hFF); send_coverage(8'h00); send_coverage(8'h11);
    drain();

    // Zero width and height act as one; alpha zero keeps the RGB.
    reconfigure(1'b1, 32'h00FF_FFFF, 1'b1, 32'd0, 1'b1, 32'd0);
    send_coverage(8'h40); send_coverage(8'h01); send_coverage(8'h02); send_coverage(8'h03);
    drain();

    while (items_sent < 1100) begin
      case ($urandom_range(3))
        0:       color = 32'hFFFF_FFFF;
        1:       color = 32'h0000_0000;
        2:       color = {8'h00, 24'($urandom)};
        default: color = $urandom;
      endcase
      case ($urandom_range(9))
        0:       width = 0;
        1:       width = $urandom_range(4095, 4092);
        default: width = $urandom_range(12, 1);
      endcase
      case ($urandom_range(9))
        0:       height = 0;
        1:       height = $urandom_range(8191, 4096);
        2:       height = $urandom_range(40, 5);
        default: height = $urandom_range(4, 1);
      endcase
      // Counters carry over, so some writes land mid-glyph.
      reconfigure(1'($urandom_range(1)), color, 1'($urandom_range(1)), width,
                  1'($urandom_range(1)), height);
      n = $urandom_range(60, 10);
      repeat (n) send_coverage(rand_coverage());
      drain();
    end

    // Widest row: 4095 pixels padded to 4096 bytes.
    reconfigure(1'b1, $urandom, 1'b1, 32'd4095, 1'b1, 32'd1);
    repeat (20) send_coverage(rand_coverage());
    drain();
    // Oversized height clamps to 4096 rows.
    reconfigure(1'b1, $urandom, 1'b1, 32'd1, 1'b1, 32'd8191);
    repeat (20) send_coverage(rand_coverage());
    drain();
    repeat (10) @(posedge clk);

    $display("Coverage items sent: %0d; pixels checked: %0d; glyph ends seen: %0d",
             items_sent, sb.checked, sb.glyph_ends);
    $display("Register writes: %0d, including zero, widest and oversized glyph sizes",
             sb.reg_writes);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/gca_pkg.sv
design/gca_coverage_if.sv
design/gca_pixel_if.sv
design/gray_coverage_to_argb_pixels_unit.sv
test/gray_coverage_to_argb_pixels_unit_tb.sv
